### rtl/core/uart_ring_buffers_defines.svh
// Assertion macros for the UART ring buffer block.
`ifndef UART_RING_BUFFERS_DEFINES_SVH
`define UART_RING_BUFFERS_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define URB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("urb assertion failed");

// Next-cycle implication.
`define URB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("urb assertion failed");

`else

`define URB_ASSERT_NOW(label, clk, rst, ante, cons)
`define URB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/uart_rb_pkg.sv
`default_nettype none

package uart_rb_pkg;

   localparam int QUEUE_DEPTH = 128;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   typedef logic [PTR_W-1:0] ptr_type;

   typedef enum logic [1:0] {
      OP_RX_BYTE    = 2'd0,
      OP_HOST_READ  = 2'd1,
      OP_HOST_WRITE = 2'd2,
      OP_TX_DONE    = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       underrun;
      logic       rx_dropped;
      logic       tx_refused;
      logic       send_strobe;
      logic [7:0] send_byte;
   } rsp_type;

   // one port pair of a ring store
   typedef struct packed {
      logic       wr_en;
      ptr_type    wr_addr;
      logic [7:0] wr_data;
      logic       rd_en;
      ptr_type    rd_addr;
   } mem_cmd_type;

   // item waiting on the store read
   typedef struct packed {
      logic       valid;
      logic       from_rx;
      logic       from_tx;
      logic       underrun;
      logic       rx_dropped;
      logic       tx_refused;
      logic       send_strobe;
      logic [7:0] send_byte;
   } stage_type;

   function automatic ptr_type ptr_next(input ptr_type p);
      return (p == ptr_type'(QUEUE_DEPTH - 1)) ? '0 : ptr_type'(p + 1'b1);
   endfunction

endpackage

`default_nettype wire

### rtl/core/uart_rb_ram.sv
`default_nettype none

module uart_rb_ram #(
   parameter int DEPTH  = 128,
   parameter int DATA_W = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read while no new read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/uart_rb_ctrl.sv
`default_nettype none

module uart_rb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire uart_rb_pkg::req_type    req_data,
   input  wire logic                    out_hold,
   output      logic                    req_stall,
   output      uart_rb_pkg::mem_cmd_type rx_cmd,
   output      uart_rb_pkg::mem_cmd_type tx_cmd,
   output      uart_rb_pkg::stage_type  stage
);

   uart_rb_pkg::ptr_type rx_wr_ff, rx_wr_in;
   uart_rb_pkg::ptr_type rx_rd_ff, rx_rd_in;
   uart_rb_pkg::ptr_type tx_wr_ff, tx_wr_in;
   uart_rb_pkg::ptr_type tx_rd_ff, tx_rd_in;
   logic                 tx_busy_ff, tx_busy_in;
   uart_rb_pkg::stage_type stage_ff, stage_in, item;
   logic                 accept;
   logic                 rx_full, rx_empty, tx_full, tx_empty;

   assign req_stall = stage_ff.valid && out_hold;
   assign accept    = req_valid && !req_stall;

   assign rx_full  = (uart_rb_pkg::ptr_next(rx_wr_ff) == rx_rd_ff);
   assign rx_empty = (rx_wr_ff == rx_rd_ff);
   assign tx_full  = (uart_rb_pkg::ptr_next(tx_wr_ff) == tx_rd_ff);
   assign tx_empty = (tx_wr_ff == tx_rd_ff);

   always_comb begin
      rx_wr_in   = rx_wr_ff;
      rx_rd_in   = rx_rd_ff;
      tx_wr_in   = tx_wr_ff;
      tx_rd_in   = tx_rd_ff;
      tx_busy_in = tx_busy_ff;
      item       = '0;
      item.valid = 1'b1;

      rx_cmd         = '0;
      rx_cmd.wr_addr = rx_wr_ff;
      rx_cmd.wr_data = req_data.data_byte;
      rx_cmd.rd_addr = rx_rd_ff;
      tx_cmd         = '0;
      tx_cmd.wr_addr = tx_wr_ff;
      tx_cmd.wr_data = req_data.data_byte;
      tx_cmd.rd_addr = tx_rd_ff;

      unique case (uart_rb_pkg::op_type'(req_data.operation))
         uart_rb_pkg::OP_RX_BYTE: begin
            if (rx_full) begin
               item.rx_dropped = 1'b1;
            end else begin
               rx_cmd.wr_en = accept;
               rx_wr_in     = uart_rb_pkg::ptr_next(rx_wr_ff);
            end
         end
         uart_rb_pkg::OP_HOST_READ: begin
            if (rx_empty) begin
               item.underrun = 1'b1;
            end else begin
               rx_cmd.rd_en = accept;
               item.from_rx = 1'b1;
               rx_rd_in     = uart_rb_pkg::ptr_next(rx_rd_ff);
            end
         end
         uart_rb_pkg::OP_HOST_WRITE: begin
            if (tx_full) begin
               item.tx_refused = 1'b1;
            end else begin
               tx_cmd.wr_en = accept;
               tx_wr_in     = uart_rb_pkg::ptr_next(tx_wr_ff);
               // idle transmitter takes the byte straight away
               if (!tx_busy_ff) begin
                  item.send_strobe = 1'b1;
                  item.send_byte   = req_data.data_byte;
                  tx_rd_in         = uart_rb_pkg::ptr_next(tx_rd_ff);
                  tx_busy_in       = 1'b1;
               end
            end
         end
         uart_rb_pkg::OP_TX_DONE: begin
            if (!tx_empty) begin
               tx_cmd.rd_en = accept;
               item.from_tx = 1'b1;
               tx_rd_in     = uart_rb_pkg::ptr_next(tx_rd_ff);
            end else begin
               tx_busy_in = 1'b0;
            end
         end
         default: begin
            item.valid = 1'b1;
         end
      endcase

      if (accept) begin
         stage_in = item;
      end else if (!out_hold) begin
         stage_in       = stage_ff;
         stage_in.valid = 1'b0;
      end else begin
         stage_in = stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff       <= '0;
         rx_rd_ff       <= '0;
         tx_wr_ff       <= '0;
         tx_rd_ff       <= '0;
         tx_busy_ff     <= 1'b0;
         stage_ff       <= '0;
      end else begin
         if (accept) begin
            rx_wr_ff   <= rx_wr_in;
            rx_rd_ff   <= rx_rd_in;
            tx_wr_ff   <= tx_wr_in;
            tx_rd_ff   <= tx_rd_in;
            tx_busy_ff <= tx_busy_in;
         end
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

### rtl/core/uart_ring_buffers.sv
// Channel   Ports                              Moves
// request   req_valid, req_stall, req_data     one event: operation and data byte
// response  rsp_valid, rsp_stall, rsp_data     one result per event, in order
//
// One transaction is accepted per cycle while req_stall is low; its result is offered
// on rsp after the registered store read and the response register.
// Reset clears the four queue pointers, the busy flag and the pipeline valids;
// the stores themselves are not cleared.
// A stalled response holds its stage; req_stall rises only while rsp_stall holds
// off a full response register and the store-read stage is also full.
`default_nettype none
`include "uart_ring_buffers_defines.svh"

module uart_ring_buffers (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire uart_rb_pkg::req_type req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      uart_rb_pkg::rsp_type rsp_data
);

   uart_rb_pkg::mem_cmd_type rx_cmd, tx_cmd;
   uart_rb_pkg::stage_type   stage;
   logic [7:0]               rx_rd_data, tx_rd_data;
   logic                     out_hold;
   logic                     rsp_valid_ff, rsp_valid_in;
   uart_rb_pkg::rsp_type     rsp_ff, rsp_in;
   logic [3:0]               rsp_flags;

   assign out_hold = rsp_valid_ff && rsp_stall;

   uart_rb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .out_hold  (out_hold),
      .req_stall (req_stall),
      .rx_cmd    (rx_cmd),
      .tx_cmd    (tx_cmd),
      .stage     (stage)
   );

   uart_rb_ram #(
      .DEPTH  (uart_rb_pkg::QUEUE_DEPTH),
      .DATA_W (8)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_cmd.wr_en),
      .wr_addr (rx_cmd.wr_addr),
      .wr_data (rx_cmd.wr_data),
      .rd_en   (rx_cmd.rd_en),
      .rd_addr (rx_cmd.rd_addr),
      .rd_data (rx_rd_data)
   );

   uart_rb_ram #(
      .DEPTH  (uart_rb_pkg::QUEUE_DEPTH),
      .DATA_W (8)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_cmd.wr_en),
      .wr_addr (tx_cmd.wr_addr),
      .wr_data (tx_cmd.wr_data),
      .rd_en   (tx_cmd.rd_en),
      .rd_addr (tx_cmd.rd_addr),
      .rd_data (tx_rd_data)
   );

   always_comb begin
      rsp_in.read_byte   = stage.from_rx ? rx_rd_data : 8'h00;
      rsp_in.underrun    = stage.underrun;
      rsp_in.rx_dropped  = stage.rx_dropped;
      rsp_in.tx_refused  = stage.tx_refused;
      rsp_in.send_strobe = stage.send_strobe || stage.from_tx;
      rsp_in.send_byte   = stage.from_tx ? tx_rd_data : stage.send_byte;
      rsp_valid_in       = out_hold || stage.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // advance the response register only when it is free or being taken
   always_ff @(posedge clock) begin
      if (!out_hold && stage.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rsp_flags = {rsp_ff.underrun, rsp_ff.rx_dropped, rsp_ff.tx_refused,
                       rsp_ff.send_strobe};

   `URB_ASSERT_NOW(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid_ff && stage.valid)
   `URB_ASSERT_NOW(a_one_source, clock, reset, stage.valid, !(stage.from_rx && stage.from_tx))
   `URB_ASSERT_NOW(a_flags_excl, clock, reset, rsp_valid_ff, $countones(rsp_flags) <= 1)
   `URB_ASSERT_NEXT(a_stage_moves, clock, reset, stage.valid && !out_hold, rsp_valid_ff)

endmodule

`default_nettype wire
